@@ design/sbc_pkg.sv @@
package sbc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // edge differences and their magnitudes carry one extra bit
  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int MAG_W      = COORD_WIDTH + 1;
  localparam int REM_W      = MAG_W + 1;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int RAT_W      = QUO_W + 1;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PROD_W     = MAG_W + QUO_W;
  localparam int SCL_W      = PROD_W - FRAC_BITS;
  localparam int NUM_EDGES  = 4;

  localparam logic [QUO_W-1:0] U_ONE = QUO_W'(1) << FRAC_BITS;
  localparam logic [QUO_W-1:0] U_SAT = U_ONE + QUO_W'(1);

  localparam int EDGE_LEFT   = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_BOTTOM = 2;
  localparam int EDGE_TOP    = 3;

  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_CLIP_Y = 2'd1;
  localparam logic [1:0] MODE_CLIP_X = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [1:0] clip_mode;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
    coord_t     box_left;
    coord_t     box_right;
    coord_t     box_bottom;
    coord_t     box_top;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t clip_first_x;
    coord_t clip_first_y;
    coord_t clip_second_x;
    coord_t clip_second_y;
    logic   first_valid;
    logic   second_valid;
  } out_t;

endpackage

@@ design/sbc_div.sv @@
module sbc_div (
  input  logic                           clk_i,
  input  logic [sbc_pkg::DIV_STAGES-1:0] en_i,
  input  logic [sbc_pkg::MAG_W-1:0]      num_i,
  input  logic [sbc_pkg::MAG_W-1:0]      den_i,
  output logic [sbc_pkg::QUO_W-1:0]      quo_o
);
  import sbc_pkg::*;

  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [MAG_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0] rem_in, rem_d;
    logic [MAG_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in, quo_d;

    if (s == 0) begin : g_head
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // restoring steps; the very first step compares without a shift
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < QUO_W) begin
          if (s * DIV_STEP + j > 0) rem_d = {rem_d[REM_W-2:0], 1'b0};
          if (rem_d >= {1'b0, den_in}) begin
            rem_d = rem_d - {1'b0, den_in};
            quo_d = {quo_d[QUO_W-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

@@ design/segment_box_clipper.sv @@
// Stages: edge-term and magnitude stages A and B, the divider stages, then bound,
// multiply, endpoint and output stages.
// Throughput: one segment per cycle while out_stall_i is low; the four q/p
// dividers resolve two quotient bits per stage, setting the pipeline depth.
// Reset clears the stage valid bits only; payload registers are not reset.
module segment_box_clipper (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  sbc_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output sbc_pkg::out_t out_data_o
);
  import sbc_pkg::*;

  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_D0  = 2;
  localparam int ST_U   = ST_D0 + DIV_STAGES;
  localparam int ST_M   = ST_U + 1;
  localparam int ST_E   = ST_M + 1;
  localparam int ST_O   = ST_E + 1;
  localparam int NUM_ST = ST_O + 1;

  typedef logic [NUM_EDGES-1:0] edge_mask_t;

  typedef struct packed {
    in_t             item;
    logic [NUM_EDGES-1:0][DIFF_W-1:0] p;
    logic [NUM_EDGES-1:0][DIFF_W-1:0] q;
  } a_t;

  typedef struct packed {
    in_t              item;
    logic             dx_neg;
    logic             dy_neg;
    logic [MAG_W-1:0] dx_mag;
    logic [MAG_W-1:0] dy_mag;
    edge_mask_t       upd_lo;
    edge_mask_t       upd_hi;
    edge_mask_t       rneg;
    edge_mask_t       sat;
    logic             rej;
  } side_t;

  typedef struct packed {
    side_t side;
    logic [NUM_EDGES-1:0][MAG_W-1:0] aq;
    logic [NUM_EDGES-1:0][MAG_W-1:0] ap;
  } b_t;

  typedef struct packed {
    side_t            side;
    logic [QUO_W-1:0] u_lo;
    logic [QUO_W-1:0] u_hi;
  } u_t;

  typedef struct packed {
    in_t  item;
    logic dx_neg;
    logic dy_neg;
    logic lo_zero;
    logic hi_one;
    logic rej;
    logic [NUM_EDGES-1:0][PROD_W-1:0] prod;
  } m_t;

  typedef struct packed {
    in_t    item;
    coord_t cx1;
    coord_t cy1;
    coord_t cx2;
    coord_t cy2;
    logic   rej;
  } e_t;

  function automatic logic signed [DIFF_W-1:0] sx(coord_t v);
    return {v[COORD_WIDTH-1], v};
  endfunction

  function automatic logic signed [SCL_W-1:0] sxs(coord_t v);
    return {{(SCL_W - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic logic signed [SCL_W-1:0] scl(logic [PROD_W-1:0] prod, logic neg);
    logic signed [SCL_W-1:0] m;
    m = $signed(prod[PROD_W-1:FRAC_BITS]);
    return neg ? -m : m;
  endfunction

  // ---------------- flow control: bubbles collapse ----------------
  logic [NUM_ST-1:0] v_q, v_d, en;

  always_comb begin
    en[NUM_ST-1] = !v_q[NUM_ST-1] || !out_stall_i;
    for (int k = NUM_ST - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_comb begin
    for (int k = 0; k < NUM_ST; k++) begin
      if (k == 0) v_d[k] = en[k] ? in_valid_i : v_q[k];
      else        v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o = !en[ST_A];

  // ---------------- stage A: edge terms ----------------
  a_t a_d, a_q;
  logic signed [DIFF_W-1:0] dx_w, dy_w;

  always_comb begin
    a_d.item = in_data_i;
    dx_w = sx(in_data_i.second_x) - sx(in_data_i.first_x);
    dy_w = sx(in_data_i.second_y) - sx(in_data_i.first_y);
    a_d.p[EDGE_LEFT]   = -dx_w;
    a_d.q[EDGE_LEFT]   = sx(in_data_i.first_x) - sx(in_data_i.box_left);
    a_d.p[EDGE_RIGHT]  = dx_w;
    a_d.q[EDGE_RIGHT]  = sx(in_data_i.box_right) - sx(in_data_i.first_x);
    a_d.p[EDGE_BOTTOM] = -dy_w;
    a_d.q[EDGE_BOTTOM] = sx(in_data_i.first_y) - sx(in_data_i.box_bottom);
    a_d.p[EDGE_TOP]    = dy_w;
    a_d.q[EDGE_TOP]    = sx(in_data_i.box_top) - sx(in_data_i.first_y);
  end

  // ---------------- stage B: magnitudes, signs, zero tests ----------------
  b_t b_d, b_q;
  edge_mask_t act, pneg, qneg, pzero;

  always_comb begin
    act[EDGE_LEFT]   = a_q.item.clip_mode != MODE_CLIP_Y;
    act[EDGE_RIGHT]  = a_q.item.clip_mode != MODE_CLIP_Y;
    act[EDGE_BOTTOM] = a_q.item.clip_mode != MODE_CLIP_X;
    act[EDGE_TOP]    = a_q.item.clip_mode != MODE_CLIP_X;
    b_d.side.item = a_q.item;
    for (int e = 0; e < NUM_EDGES; e++) begin
      pneg[e]  = a_q.p[e][DIFF_W-1];
      qneg[e]  = a_q.q[e][DIFF_W-1];
      pzero[e] = a_q.p[e] == '0;
      b_d.ap[e] = pneg[e] ? MAG_W'(-a_q.p[e]) : MAG_W'(a_q.p[e]);
      b_d.aq[e] = qneg[e] ? MAG_W'(-a_q.q[e]) : MAG_W'(a_q.q[e]);
      b_d.side.sat[e]  = b_d.aq[e] > b_d.ap[e];
      b_d.side.rneg[e] = pneg[e] ^ qneg[e];
    end
    b_d.side.upd_lo = act & ~pzero & pneg;
    b_d.side.upd_hi = act & ~pzero & ~pneg;
    // a parallel edge that lies outside rejects at once
    b_d.side.rej    = (a_q.item.clip_mode == MODE_NONE) || |(act & pzero & qneg);
    b_d.side.dx_neg = pneg[EDGE_RIGHT];
    b_d.side.dx_mag = b_d.ap[EDGE_RIGHT];
    b_d.side.dy_neg = pneg[EDGE_TOP];
    b_d.side.dy_mag = b_d.ap[EDGE_TOP];
  end

  // ---------------- divider stages ----------------
  side_t sd_q [DIV_STAGES];
  logic [NUM_EDGES-1:0][QUO_W-1:0] quo;

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
    sbc_div u_div (
      .clk_i (clk_i),
      .en_i  (en[ST_D0 +: DIV_STAGES]),
      .num_i (b_q.aq[e]),
      .den_i (b_q.ap[e]),
      .quo_o (quo[e])
    );
  end

  // ---------------- stage U: entry/exit parameters ----------------
  u_t u_d, u_q;
  side_t sd_last;
  logic signed [RAT_W-1:0] r_s, lo_s, hi_s;
  logic [QUO_W-1:0] mg;

  assign sd_last = sd_q[DIV_STAGES-1];

  always_comb begin
    lo_s = '0;
    hi_s = $signed({1'b0, U_ONE});
    for (int e = 0; e < NUM_EDGES; e++) begin
      mg  = sd_last.sat[e] ? U_SAT : quo[e];
      r_s = sd_last.rneg[e] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
      if (sd_last.upd_lo[e] && r_s > lo_s) lo_s = r_s;
      if (sd_last.upd_hi[e] && r_s < hi_s) hi_s = r_s;
    end
    u_d.side     = sd_last;
    u_d.side.rej = sd_last.rej || (lo_s > hi_s);
    u_d.u_lo     = lo_s[QUO_W-1:0];
    u_d.u_hi     = hi_s[QUO_W-1:0];
  end

  // ---------------- stage M: products ----------------
  m_t m_d, m_q;

  always_comb begin
    m_d.item    = u_q.side.item;
    m_d.dx_neg  = u_q.side.dx_neg;
    m_d.dy_neg  = u_q.side.dy_neg;
    m_d.rej     = u_q.side.rej;
    m_d.lo_zero = u_q.u_lo == '0;
    m_d.hi_one  = u_q.u_hi == U_ONE;
    m_d.prod[0] = PROD_W'(u_q.side.dx_mag) * PROD_W'(u_q.u_lo);
    m_d.prod[1] = PROD_W'(u_q.side.dy_mag) * PROD_W'(u_q.u_lo);
    m_d.prod[2] = PROD_W'(u_q.side.dx_mag) * PROD_W'(u_q.u_hi);
    m_d.prod[3] = PROD_W'(u_q.side.dy_mag) * PROD_W'(u_q.u_hi);
  end

  // ---------------- stage E: clipped endpoints ----------------
  e_t e_d, e_q;
  logic signed [SCL_W-1:0] sx1, sy1, sx2, sy2;

  always_comb begin
    sx1 = sxs(m_q.item.first_x) + scl(m_q.prod[0], m_q.dx_neg);
    sy1 = sxs(m_q.item.first_y) + scl(m_q.prod[1], m_q.dy_neg);
    sx2 = sxs(m_q.item.first_x) + scl(m_q.prod[2], m_q.dx_neg);
    sy2 = sxs(m_q.item.first_y) + scl(m_q.prod[3], m_q.dy_neg);
    e_d.item = m_q.item;
    e_d.rej  = m_q.rej;
    e_d.cx1  = m_q.lo_zero ? m_q.item.first_x  : sx1[COORD_WIDTH-1:0];
    e_d.cy1  = m_q.lo_zero ? m_q.item.first_y  : sy1[COORD_WIDTH-1:0];
    e_d.cx2  = m_q.hi_one  ? m_q.item.second_x : sx2[COORD_WIDTH-1:0];
    e_d.cy2  = m_q.hi_one  ? m_q.item.second_y : sy2[COORD_WIDTH-1:0];
  end

  // ---------------- stage O: bound tests, output register ----------------
  out_t o_d, o_q;
  logic v1, v2;

  always_comb begin
    unique case (e_q.item.clip_mode)
      MODE_CLIP_Y: begin
        v1 = ($signed(e_q.item.box_left) <= $signed(e_q.cx1)) &&
             ($signed(e_q.cx1) <= $signed(e_q.item.box_right));
        v2 = ($signed(e_q.item.box_left) <= $signed(e_q.cx2)) &&
             ($signed(e_q.cx2) <= $signed(e_q.item.box_right));
      end
      MODE_CLIP_X: begin
        v1 = ($signed(e_q.item.box_bottom) <= $signed(e_q.cy1)) &&
             ($signed(e_q.cy1) <= $signed(e_q.item.box_top));
        v2 = ($signed(e_q.item.box_bottom) <= $signed(e_q.cy2)) &&
             ($signed(e_q.cy2) <= $signed(e_q.item.box_top));
      end
      MODE_FULL, MODE_NONE: begin
        v1 = 1'b1;
        v2 = 1'b1;
      end
    endcase
    if (e_q.rej) begin
      o_d = '0;
    end else begin
      o_d.hit           = v1 || v2;
      o_d.clip_first_x  = e_q.cx1;
      o_d.clip_first_y  = e_q.cy1;
      o_d.clip_second_x = e_q.cx2;
      o_d.clip_second_y = e_q.cy2;
      o_d.first_valid   = v1;
      o_d.second_valid  = v2;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (en[ST_A]) a_q <= a_d;
    if (en[ST_B]) b_q <= b_d;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[ST_D0 + s]) begin
        if (s == 0) sd_q[s] <= b_q.side;
        else        sd_q[s] <= sd_q[s-1];
      end
    end
    if (en[ST_U]) u_q <= u_d;
    if (en[ST_M]) m_q <= m_d;
    if (en[ST_E]) e_q <= e_d;
    if (en[ST_O]) o_q <= o_d;
  end

  assign out_valid_o = v_q[ST_O];
  assign out_data_o  = o_q;

  // ---------------- assertions ----------------
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[ST_A])
    else $error("transfer did not enter the first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &v_q)
    else $error("input stalled while a stage holds a bubble");

  a_hit_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hit == (out_data_o.first_valid || out_data_o.second_valid))
    else $error("hit disagrees with endpoint flags");

endmodule

@@ bench/tb_segment_box_clipper.sv @@
`timescale 1ns / 100ps

module tb_segment_box_clipper;
  import sbc_pkg::*;

  localparam int UFRAC = FRAC_BITS;
  localparam longint UONE = longint'(1) << UFRAC;
  localparam int LATENCY = 15;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  segment_box_clipper uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  in_t    segs_pending[$];
  out_t   clips_expected[$];
  int     errors;
  int     segs_sent;
  int     clips_seen;
  int     hits_seen;
  int     send_gap;
  int     recv_gap;
  int     hold_off;
  bit     hold_done;
  bit     stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // q/p with saturation just past one, truncated toward zero
  function automatic longint clip_ratio(longint q, longint p);
    longint aq, ap, r, quo;
    bit     neg;
    aq  = q < 0 ? -q : q;
    ap  = p < 0 ? -p : p;
    neg = (q < 0) != (p < 0);
    quo = 0;
    if (aq > ap) begin
      quo = UONE + 1;
    end else begin
      r = aq;
      if (r >= ap) begin
        quo = 1;
        r -= ap;
      end
      for (int i = 0; i < UFRAC; i++) begin
        r   = r << 1;
        quo = quo << 1;
        if (r >= ap) begin
          quo |= 1;
          r -= ap;
        end
      end
    end
    return neg ? -quo : quo;
  endfunction

  function automatic bit clip_edge(longint p, longint q, inout longint u1, inout longint u2);
    longint r;
    if (p == 0) return q >= 0;
    r = clip_ratio(q, p);
    if (p < 0) begin
      if (r > u1) u1 = r;
    end else begin
      if (r < u2) u2 = r;
    end
    return 1'b1;
  endfunction

  function automatic longint scale_delta(longint d, longint u);
    longint m, res;
    m   = d < 0 ? -d : d;
    res = (m >> UFRAC) * u + (((m & (UONE - 1)) * u) >> UFRAC);
    return d < 0 ? -res : res;
  endfunction

  function automatic out_t clip_segment(in_t s);
    out_t   o;
    longint x1, y1, x2, y2, bl, br, bb, bt, dx, dy, u1, u2;
    longint cx1, cy1, cx2, cy2;
    bit     ok, v1, v2;
    o  = '0;
    x1 = longint'(s.first_x);
    y1 = longint'(s.first_y);
    x2 = longint'(s.second_x);
    y2 = longint'(s.second_y);
    bl = longint'(s.box_left);
    br = longint'(s.box_right);
    bb = longint'(s.box_bottom);
    bt = longint'(s.box_top);
    dx = x2 - x1;
    dy = y2 - y1;
    u1 = 0;
    u2 = UONE;
    ok = 1'b1;
    if (s.clip_mode == MODE_NONE) return o;
    if (s.clip_mode != MODE_CLIP_Y)
      ok = clip_edge(-dx, x1 - bl, u1, u2) && clip_edge(dx, br - x1, u1, u2);
    if (ok && s.clip_mode != MODE_CLIP_X)
      ok = clip_edge(-dy, y1 - bb, u1, u2) && clip_edge(dy, bt - y1, u1, u2);
    if (!ok || u1 > u2) return o;
    if (u1 == 0) begin
      cx1 = x1;
      cy1 = y1;
    end else begin
      cx1 = x1 + scale_delta(dx, u1);
      cy1 = y1 + scale_delta(dy, u1);
    end
    if (u2 == UONE) begin
      cx2 = x2;
      cy2 = y2;
    end else begin
      cx2 = x1 + scale_delta(dx, u2);
      cy2 = y1 + scale_delta(dy, u2);
    end
    if (s.clip_mode == MODE_FULL) begin
      v1 = 1'b1;
      v2 = 1'b1;
    end else if (s.clip_mode == MODE_CLIP_Y) begin
      v1 = bl <= cx1 && cx1 <= br;
      v2 = bl <= cx2 && cx2 <= br;
    end else begin
      v1 = bb <= cy1 && cy1 <= bt;
      v2 = bb <= cy2 && cy2 <= bt;
    end
    o.hit           = v1 | v2;
    o.clip_first_x  = coord_t'(cx1);
    o.clip_first_y  = coord_t'(cy1);
    o.clip_second_x = coord_t'(cx2);
    o.clip_second_y = coord_t'(cy2);
    o.first_valid   = v1;
    o.second_valid  = v2;
    return o;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom);
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2, 3:    return coord_t'(int'($urandom_range(0, 400)) - 200) <<< 16;
      default: return coord_t'(int'($urandom_range(0, 32'h00c80000)) - 32'sh00640000);
    endcase
  endfunction

  function automatic in_t make_seg(logic [1:0] mode, coord_t x1, coord_t y1, coord_t x2,
                                   coord_t y2, coord_t bl, coord_t br, coord_t bb,
                                   coord_t bt);
    in_t s;
    s.clip_mode  = mode;
    s.first_x    = x1;
    s.first_y    = y1;
    s.second_x   = x2;
    s.second_y   = y2;
    s.box_left   = bl;
    s.box_right  = br;
    s.box_bottom = bb;
    s.box_top    = bt;
    return s;
  endfunction

  function automatic in_t rand_seg();
    in_t    s;
    coord_t a, b;
    s = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom});
    s.clip_mode = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) != 0) begin
      s.first_x  = rand_coord();
      s.first_y  = rand_coord();
      s.second_x = rand_coord();
      s.second_y = rand_coord();
      a = rand_coord();
      b = rand_coord();
      // mostly proper boxes; sometimes inverted
      s.box_left  = (a <= b || $urandom_range(0, 9) == 0) ? a : b;
      s.box_right = (s.box_left == a) ? b : a;
      a = rand_coord();
      b = rand_coord();
      s.box_bottom = (a <= b || $urandom_range(0, 9) == 0) ? a : b;
      s.box_top    = (s.box_bottom == a) ? b : a;
      case ($urandom_range(0, 5))
        0: s.second_x = s.first_x;
        1: s.second_y = s.first_y;
        default: ;
      endcase
    end
    return s;
  endfunction

  initial begin
    coord_t mx, mn, one;
    mx  = 32'sh7fffffff;
    mn  = 32'sh80000000;
    one = 32'sh00010000;
    errors     = 0;
    segs_sent  = 0;
    clips_seen = 0;
    hits_seen  = 0;
    stim_done  = 1'b0;
    hold_done  = 1'b0;
    hold_off   = 0;
    // fully inside, crossing the box, outside, vertical/horizontal, degenerate point
    segs_pending.push_back(make_seg(MODE_FULL, one, one, 2 * one, 2 * one, 0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, -4 * one, -3 * one, 8 * one, 7 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, 5 * one, 5 * one, 9 * one, 6 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, one, -5 * one, one, 9 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, -5 * one, one, 9 * one, one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, 7 * one, one, 7 * one, 3 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, one, one, one, one, 0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_FULL, mn, mn, mx, mx, mn, mx, mn, mx));
    segs_pending.push_back(make_seg(MODE_FULL, mx, mn, mn, mx, -one, one, -one, one));
    segs_pending.push_back(make_seg(MODE_FULL, mn, mx, mx, mn, 0, 0, 0, 0));
    // inverted box
    segs_pending.push_back(make_seg(MODE_FULL, 0, 0, 2 * one, 2 * one, 4 * one, 0, 4 * one, 0));
    segs_pending.push_back(make_seg(MODE_CLIP_Y, -one, -4 * one, 3 * one, 8 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_CLIP_Y, 6 * one, -4 * one, 9 * one, 8 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_CLIP_Y, -2 * one, -4 * one, 6 * one, 8 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_CLIP_X, -4 * one, -one, 8 * one, 3 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_CLIP_X, -4 * one, 6 * one, 8 * one, 9 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_CLIP_X, mn, mx, mx, mn, mn, mx, mn, mx));
    segs_pending.push_back(make_seg(MODE_NONE, one, one, 2 * one, 2 * one,
                                    0, 4 * one, 0, 4 * one));
    segs_pending.push_back(make_seg(MODE_NONE, mx, mx, mx, mx, mx, mx, mx, mx));
    segs_pending.push_back('1);
    segs_pending.push_back('0);
    for (int i = 0; i < 1300; i++) segs_pending.push_back(rand_seg());
    stim_done = 1'b1;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        clips_expected.push_back(clip_segment(in_data_i));
        segs_sent <= segs_sent + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the offered segment
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (segs_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= segs_pending.pop_front();
        send_gap   <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall; one long hold-off once traffic is flowing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap    <= 0;
    end else if (!hold_done && segs_sent == 300) begin
      hold_done   <= 1'b1;
      hold_off    <= 80;
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_stall_i <= hold_off > 1;
    end else if (recv_gap > 0) begin
      recv_gap    <= recv_gap - 1;
      out_stall_i <= recv_gap > 1;
    end else if (out_valid_o && !out_stall_i && $urandom_range(0, 2) == 0) begin
      recv_gap    <= $urandom_range(1, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      clips_seen <= clips_seen + 1;
      if (out_data_o.hit) hits_seen <= hits_seen + 1;
      if (clips_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors <= errors + 1;
      end else begin
        want = clips_expected.pop_front();
        if (want.hit !== out_data_o.hit)
          $display("%0t: hit expected %b got %b", $time, want.hit, out_data_o.hit);
        if (want.clip_first_x !== out_data_o.clip_first_x)
          $display("%0t: clip_first_x expected %h got %h", $time, want.clip_first_x,
                   out_data_o.clip_first_x);
        if (want.clip_first_y !== out_data_o.clip_first_y)
          $display("%0t: clip_first_y expected %h got %h", $time, want.clip_first_y,
                   out_data_o.clip_first_y);
        if (want.clip_second_x !== out_data_o.clip_second_x)
          $display("%0t: clip_second_x expected %h got %h", $time, want.clip_second_x,
                   out_data_o.clip_second_x);
        if (want.clip_second_y !== out_data_o.clip_second_y)
          $display("%0t: clip_second_y expected %h got %h", $time, want.clip_second_y,
                   out_data_o.clip_second_y);
        if (want.first_valid !== out_data_o.first_valid)
          $display("%0t: first_valid expected %b got %b", $time, want.first_valid,
                   out_data_o.first_valid);
        if (want.second_valid !== out_data_o.second_valid)
          $display("%0t: second_valid expected %b got %b", $time, want.second_valid,
                   out_data_o.second_valid);
        if (want !== out_data_o) errors <= errors + 1;
      end
    end
  end

  initial begin
    wait (rst_ni && stim_done);
    wait (segs_pending.size() == 0 && !in_valid_i);
    wait (clips_expected.size() == 0);
    repeat (LATENCY * 3) @(posedge clk_i);
    $display("Sent %0d segments, checked %0d clipped results (%0d hits).", segs_sent,
             clips_seen, hits_seen);
    $display("Covered all clip modes, extreme coordinates, inverted boxes and backpressure.");
    if (errors == 0 && clips_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
